// ===== src/tsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and constants for the two-stack queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic                     now_empty;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push;          // write input stack, bump its count
    logic       mv_rd;         // read input stack top, drop its count
    logic       mv_wr;         // write moved word onto output stack
    logic       pop_rd;        // read output stack top, drop its count
    logic       resp_ld;       // load the result register
    logic       resp_from_ram; // result word comes from output stack read
    logic [1:0] resp_status;
  } tsq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_empty;
    logic in_full;
    logic out_empty;
    logic out_hold;            // result register holds a stalled transaction
  } tsq_stat_t;

endpackage

// ===== src/tsq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tsq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_datapath
// Stack memories, stack counts and the result register.
// ----------------------------------------------------------------------------
module tsq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsq_pkg::tsq_cmd_t  cmd_i,
  input  logic [31:0]        in_value_i,
  input  logic               out_stall_i,
  output tsq_pkg::tsq_stat_t stat_o,
  output logic               out_valid_o,
  output tsq_pkg::out_item_t out_item_o
);
  import tsq_pkg::*;

  logic [CNT_W-1:0]  in_cnt_q, in_cnt_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [CNT_W-1:0]  in_top, out_top;
  logic [DATA_W-1:0] in_rdata, out_rdata;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;

  assign in_top  = in_cnt_q - CNT_W'(1);
  assign out_top = out_cnt_q - CNT_W'(1);

  tsq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (in_cnt_q[ADDR_W-1:0]),
    .wdata_i (in_value_i),
    .raddr_i (in_top[ADDR_W-1:0]),
    .rdata_o (in_rdata)
  );

  tsq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mv_wr),
    .waddr_i (out_cnt_q[ADDR_W-1:0]),
    .wdata_i (in_rdata),
    .raddr_i (out_top[ADDR_W-1:0]),
    .rdata_o (out_rdata)
  );

  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    if (cmd_i.push) begin
      in_cnt_d = in_cnt_q + CNT_W'(1);
    end else if (cmd_i.mv_rd) begin
      in_cnt_d = in_top;
    end
    if (cmd_i.mv_wr) begin
      out_cnt_d = out_cnt_q + CNT_W'(1);
    end else if (cmd_i.pop_rd) begin
      out_cnt_d = out_top;
    end
  end

  assign out_valid_d = cmd_i.resp_ld || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_ld) begin
      out_q.out_value <= cmd_i.resp_from_ram ? out_rdata : '0;
      out_q.status    <= cmd_i.resp_status;
      out_q.now_empty <= (in_cnt_d == '0) && (out_cnt_d == '0);
    end
  end

  assign stat_o.in_empty  = (in_cnt_q == '0);
  assign stat_o.in_full   = (in_cnt_q == CNT_W'(DEPTH));
  assign stat_o.out_empty = (out_cnt_q == '0);
  assign stat_o.out_hold  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/tsq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencer for push, transfer and pop of the two-stack queue.
// ----------------------------------------------------------------------------
module tsq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  input  tsq_pkg::tsq_stat_t stat_i,
  output tsq_pkg::tsq_cmd_t  cmd_o,
  output logic               in_stall_o
);
  import tsq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE) || stat_i.out_hold;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_ENQ) begin
            cmd_o.resp_ld = 1'b1;
            if (stat_i.in_full) begin
              cmd_o.resp_status = ST_FULL;
            end else begin
              cmd_o.push        = 1'b1;
              cmd_o.resp_status = ST_DONE;
            end
          end else if (stat_i.in_empty && stat_i.out_empty) begin
            cmd_o.resp_ld     = 1'b1;
            cmd_o.resp_status = ST_EMPTY;
          end else if (!stat_i.out_empty) begin
            cmd_o.pop_rd = 1'b1;
            state_d      = S_RESP;
          end else begin
            cmd_o.mv_rd = 1'b1;
            state_d     = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        // write the word read last cycle, keep reading until input stack drains
        cmd_o.mv_wr = 1'b1;
        if (!stat_i.in_empty) begin
          cmd_o.mv_rd = 1'b1;
        end else begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        cmd_o.resp_ld       = 1'b1;
        cmd_o.resp_from_ram = 1'b1;
        cmd_o.resp_status   = ST_DONE;
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/two_stack_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_queue
// FIFO of signed 32-bit words built from an input stack and an output stack.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   -------  ---------  --------------------  ---------------------------
//   in       input      in_valid_i/in_stall_o    in_item_i  (action, word)
//   out      output     out_valid_o/out_stall_i  out_item_o (word, status,
//                                                            now_empty)
//
// Sequencing: an enqueue, a rejected enqueue or an empty dequeue answers in the
// cycle after acceptance; a dequeue from a non-empty output stack goes through
// one RAM read before it answers. A dequeue that finds the output stack empty
// first moves the N input-stack words, one per cycle through the input RAM
// read port, then pops from the output stack. Averaged over a stream, each word
// moves from the input stack to the output stack once.
// Reset clears the stack counts and the controller; the RAMs are not cleared.
// One transaction is in flight at a time; the next one is taken once the
// result register is free or is being drained in the same cycle. A stalled
// result holds in its register.
// ----------------------------------------------------------------------------
module two_stack_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsq_pkg::out_item_t out_item_o
);
  import tsq_pkg::*;

  tsq_cmd_t  cmd;
  tsq_stat_t stat;
  logic      in_accept;

  // Controller: decode the transaction and sequence the stack transfer.
  tsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_item_i.action),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Datapath: both stack RAMs, their counts and the result register.
  tsq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_value_i  (in_item_i.in_value),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  assign in_accept = in_valid_i && !in_stall_o;

  // An enqueue always answers in the next cycle.
  a_enq_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_item_i.action == ACT_ENQ) |=> out_valid_o)
    else $error("enqueue result not presented one cycle after acceptance");

  // A dequeue with data must go through a RAM read before answering.
  a_deq_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_item_i.action == ACT_DEQ) && !(stat.in_empty && stat.out_empty)
    |=> !out_valid_o)
    else $error("dequeue answered before its stack read completed");

  // An empty status must report an empty queue.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_EMPTY) |-> out_item_o.now_empty)
    else $error("empty status with a non-empty queue");

  // A failed transaction (full or empty status) must carry a zero word.
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_DONE) |-> (out_item_o.out_value == '0))
    else $error("non-zero word on a failed transaction");

  // The input stack can never be both empty and full.
  a_count_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.in_empty && stat.in_full))
    else $error("input stack count inconsistent");

endmodule
